// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file fmc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== hdl/fmc_pkg.sv =====
package fmc_pkg;

	typedef logic [3:0] file_type_t;

	localparam file_type_t TYPE_UNKNOWN = 4'd0;
	localparam file_type_t TYPE_ELF     = 4'd1;
	localparam file_type_t TYPE_PE      = 4'd2;
	localparam file_type_t TYPE_EICAR   = 4'd3;
	localparam file_type_t TYPE_LZH     = 4'd4;
	localparam file_type_t TYPE_LZW     = 4'd5;
	localparam file_type_t TYPE_PDF     = 4'd6;
	localparam file_type_t TYPE_OOXML   = 4'd7;
	localparam file_type_t TYPE_PKZIP   = 4'd8;
	localparam file_type_t TYPE_OLE     = 4'd9;
	localparam file_type_t TYPE_TAR     = 4'd10;
	localparam file_type_t TYPE_7ZIP    = 4'd11;
	localparam file_type_t TYPE_RAR     = 4'd12;

	localparam int NUM_SIGS  = 12;
	localparam int BIT_ELF   = 12;
	localparam int BIT_EICAR = 13;
	localparam int NUM_FLAGS = 14;

	localparam int SIG_PE    = 0;
	localparam int SIG_LZH   = 1;
	localparam int SIG_LZW   = 2;
	localparam int SIG_PDF   = 3;
	localparam int SIG_PK34  = 4;
	localparam int SIG_OOXML = 5;
	localparam int SIG_PK56  = 6;
	localparam int SIG_PK78  = 7;
	localparam int SIG_OLE   = 8;
	localparam int SIG_TAR   = 9;
	localparam int SIG_7ZIP  = 10;
	localparam int SIG_RAR   = 11;

	localparam int EICAR_LENGTH = 68;
	localparam logic [6:0] EICAR_LEN7  = 7'(EICAR_LENGTH);
	localparam logic [6:0] POS_MAX     = 7'd127;
	localparam logic [6:0] ELF_MIN_LEN = 7'd18;

	localparam logic [EICAR_LENGTH*8-1:0] EICAR_TEXT =
		"X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";

	localparam logic [3:0] SIG_LEN [NUM_SIGS] = '{
		4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd8, 4'd4, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7
	};

	localparam logic [7:0] SIG_BYTES [NUM_SIGS][8] = '{
		'{8'h4D, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1F, 8'hA0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1F, 8'h9D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4B, 8'h03, 8'h04, 8'h14, 8'h00, 8'h06, 8'h00},
		'{8'h50, 8'h4B, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4B, 8'h07, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00},
		'{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, 8'h00, 8'h00},
		'{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h00, 8'h00}
	};

endpackage

// ===== hdl/fmc_byte_if.sv =====
interface fmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/fmc_result_if.sv =====
interface fmc_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] file_type;
	logic [6:0] window_length;

	modport source (output valid, output file_type, output window_length, input ready);
	modport sink (input valid, input file_type, input window_length, output ready);
endinterface

// ===== hdl/fmc_cfg_if.sv =====
interface fmc_cfg_if;
	logic valid;
	logic ready;
	logic data_file_detection;

	modport source (output valid, output data_file_detection, input ready);
	modport sink (input valid, input data_file_detection, output ready);
endinterface

// ===== hdl/file_magic_classifier.sv =====
// File magic-number classifier.
// The din channel carries a file window one byte per item, starting at offset
// zero, with last_byte set on the final byte. On that final byte the dout
// channel delivers one item with the detected file type and the window length,
// saturating at 127. Bytes without last_byte produce no output item.
// The cfg channel writes the data_file_detection bit, which enables the
// archive, PDF and office checks; it is always ready and should be written
// only while no window is in flight.
// Each accepted byte is held in an input register until taken, then compared
// against the position-indexed signature bytes and folded into the match flags.
// A result is written from the input register into the result register that drives dout.
// The block takes one byte per cycle while no final byte waits on a stalled receiver;
// the rate is set by the single compare stage between the input register and the result register.
// When the receiver stalls, the result register holds its item, and only a
// final byte waits in the input register; other bytes keep flowing.
// Reset clears the position counter, sets all match flags, clears the
// detection bit and empties both registers.
module file_magic_classifier
	import fmc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	fmc_byte_if.sink      din,
	fmc_result_if.source  dout,
	fmc_cfg_if.sink       cfg
);

	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 valid_s1;
	logic [6:0]           pos_q;
	logic [NUM_FLAGS-1:0] alive_q;
	logic                 det_q;
	file_type_t           type_q;
	logic [6:0]           len_q;
	logic                 out_valid_q;

	logic                 out_free;
	logic                 s1_take;
	logic [NUM_FLAGS-1:0] alive_nx;
	logic [NUM_SIGS-1:0]  hit;
	logic                 elf_ok;
	logic [6:0]           eidx;
	logic [7:0]           eicar_byte;
	logic [6:0]           seen;
	file_type_t           ftype;

	assign out_free = !out_valid_q || dout.ready;
	assign s1_take  = valid_s1 && (!last_s1 || out_free);
	assign din.ready = !valid_s1 || s1_take;
	assign cfg.ready = 1'b1;

	assign dout.valid         = out_valid_q;
	assign dout.file_type     = type_q;
	assign dout.window_length = len_q;

	assign seen = (pos_q == POS_MAX) ? POS_MAX : pos_q + 7'd1;
	assign eidx = (pos_q < EICAR_LEN7) ? pos_q : 7'd0;
	assign eicar_byte = EICAR_TEXT[8*(EICAR_LENGTH-1-int'(eidx)) +: 8];

	always_comb begin
		case (pos_q)
			7'd0:    elf_ok = (byte_s1 == 8'h7F);
			7'd1:    elf_ok = (byte_s1 == 8'h45);
			7'd2:    elf_ok = (byte_s1 == 8'h4C);
			7'd3:    elf_ok = (byte_s1 == 8'h46);
			7'd4:    elf_ok = (byte_s1 == 8'h01) || (byte_s1 == 8'h02);
			7'd16:   elf_ok = (byte_s1 == 8'h02) || (byte_s1 == 8'h03);
			7'd17:   elf_ok = (byte_s1 == 8'h00);
			default: elf_ok = 1'b1;
		endcase
	end

	always_comb begin
		alive_nx = alive_q;
		for (int i = 0; i < NUM_SIGS; i++) begin
			if ((pos_q < {3'b000, SIG_LEN[i]}) && (byte_s1 != SIG_BYTES[i][pos_q[2:0]])) begin
				alive_nx[i] = 1'b0;
			end
		end
		if (!elf_ok) begin
			alive_nx[BIT_ELF] = 1'b0;
		end
		if ((pos_q < EICAR_LEN7) && (byte_s1 != eicar_byte)) begin
			alive_nx[BIT_EICAR] = 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_SIGS; i++) begin
			hit[i] = alive_nx[i] && (seen >= {3'b000, SIG_LEN[i]});
		end
	end

	always_comb begin
		ftype = TYPE_UNKNOWN;
		if (alive_nx[BIT_ELF] && (seen >= ELF_MIN_LEN)) begin
			ftype = TYPE_ELF;
		end else if (hit[SIG_PE]) begin
			ftype = TYPE_PE;
		end else if (alive_nx[BIT_EICAR] && (seen >= EICAR_LEN7)) begin
			ftype = TYPE_EICAR;
		end else if (det_q) begin
			if (hit[SIG_LZH]) begin
				ftype = TYPE_LZH;
			end else if (hit[SIG_LZW]) begin
				ftype = TYPE_LZW;
			end else if (hit[SIG_PDF]) begin
				ftype = TYPE_PDF;
			end else if (hit[SIG_PK34]) begin
				ftype = hit[SIG_OOXML] ? TYPE_OOXML : TYPE_PKZIP;
			end else if (hit[SIG_PK56] || hit[SIG_PK78]) begin
				ftype = TYPE_PKZIP;
			end else if (hit[SIG_OLE]) begin
				ftype = TYPE_OLE;
			end else if (hit[SIG_TAR]) begin
				ftype = TYPE_TAR;
			end else if (hit[SIG_7ZIP]) begin
				ftype = TYPE_7ZIP;
			end else if (hit[SIG_RAR]) begin
				ftype = TYPE_RAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			byte_s1 <= din.data_byte;
			last_s1 <= din.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			alive_q <= '1;
		end else if (s1_take) begin
			if (last_s1) begin
				pos_q   <= '0;
				alive_q <= '1;
			end else begin
				pos_q   <= seen;
				alive_q <= alive_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q <= 1'b0;
		end else if (cfg.valid) begin
			det_q <= cfg.data_file_detection;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && last_s1) begin
			type_q <= ftype;
			len_q  <= seen;
		end
	end

endmodule

// ===== hdl/fmc_checker.sv =====
`include "assert_macros.svh"

module fmc_checker
	import fmc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       cfg_det,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] file_type,
	input logic [6:0] window_length
);

	logic det_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			det_q <= cfg_det;
		end
	end

	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_IMP(a_type_range, clk, arst_n, out_valid, file_type <= TYPE_RAR && window_length != 7'd0)
	`ASSERT_IMP(a_elf_len, clk, arst_n, out_valid && file_type == TYPE_ELF, window_length >= ELF_MIN_LEN)
	`ASSERT_IMP(a_det_off, clk, arst_n, out_valid && !det_q, file_type <= TYPE_EICAR)

endmodule

bind file_magic_classifier fmc_checker u_fmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg.valid),
	.cfg_ready     (cfg.ready),
	.cfg_det       (cfg.data_file_detection),
	.out_valid     (dout.valid),
	.out_ready     (dout.ready),
	.file_type     (dout.file_type),
	.window_length (dout.window_length)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import fmc_pkg::*;

	localparam int KIND_ELF   = 12;
	localparam int KIND_EICAR = 13;
	localparam int KIND_NOISE = 14;
	localparam int KIND_LONG  = 15;
	localparam int CYCLE_LIMIT = 200000;

	class magic_scoreboard;
		typedef struct packed {
			file_type_t file_type;
			logic [6:0] window_length;
		} verdict_t;

		localparam logic [EICAR_LENGTH*8-1:0] EICAR_STRING =
			"X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";

		logic [15:0] alive;
		logic [6:0]  byte_pos;
		logic        detect;
		verdict_t    verdicts[$];
		int          errors;
		int          results;
		int          bytes;

		function new();
			alive = '1;
			byte_pos = '0;
			detect = 1'b0;
			errors = 0;
			results = 0;
			bytes = 0;
		endfunction

		static function logic [63:0] pattern(int s);
			case (s)
				SIG_PE:    return 64'h4D5A_0000_0000_0000;
				SIG_LZH:   return 64'h1FA0_0000_0000_0000;
				SIG_LZW:   return 64'h1F9D_0000_0000_0000;
				SIG_PDF:   return 64'h2550_4446_0000_0000;
				SIG_PK34:  return 64'h504B_0304_0000_0000;
				SIG_OOXML: return 64'h504B_0304_1400_0600;
				SIG_PK56:  return 64'h504B_0506_0000_0000;
				SIG_PK78:  return 64'h504B_0708_0000_0000;
				SIG_OLE:   return 64'hD0CF_11E0_0000_0000;
				SIG_TAR:   return 64'h7573_7461_7200_0000;
				SIG_7ZIP:  return 64'h377A_BCAF_271C_0000;
				default:   return 64'h5261_7221_1A07_0000;
			endcase
		endfunction

		static function int pattern_len(int s);
			case (s)
				SIG_PE, SIG_LZH, SIG_LZW: return 2;
				SIG_OOXML:                return 8;
				SIG_TAR:                  return 5;
				SIG_7ZIP:                 return 6;
				SIG_RAR:                  return 7;
				default:                  return 4;
			endcase
		endfunction

		static function logic [7:0] eicar_char(int p);
			return EICAR_STRING[(EICAR_LENGTH-1-p)*8 +: 8];
		endfunction

		function bit hit(int s, int seen);
			return alive[s] && seen >= pattern_len(s);
		endfunction

		function void set_detection(logic v);
			detect = v;
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			int pos;
			int seen;
			bit elf_ok;
			logic [63:0] pat;
			verdict_t v;
			pos = byte_pos;
			bytes++;
			for (int s = 0; s < NUM_SIGS; s++) begin
				pat = pattern(s);
				if (pos < pattern_len(s) && b != pat[63-8*pos -: 8])
					alive[s] = 1'b0;
			end
			case (pos)
				0:       elf_ok = (b == 8'h7F);
				1:       elf_ok = (b == 8'h45);
				2:       elf_ok = (b == 8'h4C);
				3:       elf_ok = (b == 8'h46);
				4:       elf_ok = (b == 8'h01 || b == 8'h02);
				16:      elf_ok = (b == 8'h02 || b == 8'h03);
				17:      elf_ok = (b == 8'h00);
				default: elf_ok = 1'b1;
			endcase
			if (!elf_ok)
				alive[BIT_ELF] = 1'b0;
			if (pos < EICAR_LENGTH && b != eicar_char(pos))
				alive[BIT_EICAR] = 1'b0;
			seen = (pos >= int'(POS_MAX)) ? int'(POS_MAX) : pos + 1;
			if (!last) begin
				byte_pos = 7'(seen);
				return;
			end
			v.file_type = TYPE_UNKNOWN;
			if (alive[BIT_ELF] && seen >= int'(ELF_MIN_LEN))
				v.file_type = TYPE_ELF;
			else if (hit(SIG_PE, seen))
				v.file_type = TYPE_PE;
			else if (alive[BIT_EICAR] && seen >= EICAR_LENGTH)
				v.file_type = TYPE_EICAR;
			else if (detect) begin
				if (hit(SIG_LZH, seen))
					v.file_type = TYPE_LZH;
				else if (hit(SIG_LZW, seen))
					v.file_type = TYPE_LZW;
				else if (hit(SIG_PDF, seen))
					v.file_type = TYPE_PDF;
				else if (hit(SIG_PK34, seen))
					v.file_type = hit(SIG_OOXML, seen) ? TYPE_OOXML : TYPE_PKZIP;
				else if (hit(SIG_PK56, seen) || hit(SIG_PK78, seen))
					v.file_type = TYPE_PKZIP;
				else if (hit(SIG_OLE, seen))
					v.file_type = TYPE_OLE;
				else if (hit(SIG_TAR, seen))
					v.file_type = TYPE_TAR;
				else if (hit(SIG_7ZIP, seen))
					v.file_type = TYPE_7ZIP;
				else if (hit(SIG_RAR, seen))
					v.file_type = TYPE_RAR;
			end
			v.window_length = 7'(seen);
			verdicts.push_back(v);
			byte_pos = '0;
			alive = '1;
		endfunction

		function void check_result(file_type_t ft, logic [6:0] len);
			verdict_t want;
			results++;
			if (verdicts.size() == 0) begin
				$error("unexpected result: file_type %0d window_length %0d", ft, len);
				errors++;
				return;
			end
			want = verdicts.pop_front();
			if (ft !== want.file_type) begin
				$error("file_type: expected %0d, actual %0d", want.file_type, ft);
				errors++;
			end
			if (len !== want.window_length) begin
				$error("window_length: expected %0d, actual %0d", want.window_length, len);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fmc_byte_if   din();
	fmc_result_if dout();
	fmc_cfg_if    cfg();

	file_magic_classifier u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg)
	);

	magic_scoreboard sb;
	bit steady;
	bit holding;
	int hold_len;
	int sent;
	int windows;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (dout.valid && dout.ready)
				sb.check_result(dout.file_type, dout.window_length);
			if (cfg.valid && cfg.ready)
				sb.set_detection(cfg.data_file_detection);
			if (din.valid && din.ready)
				sb.note_byte(din.data_byte, din.last_byte);
		end
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int g;
		int held;
		dout.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				dout.ready <= 1'b0;
				holding = 1'b1;
				held = 0;
				while (held < hold_len) begin
					@(posedge clk);
					held++;
				end
				hold_len = 0;
				holding = 1'b0;
			end
			dout.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			g = steady ? 0 : idle_gap();
			if (g > 0) begin
				dout.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last);
		int g;
		din.valid <= 1'b1;
		din.data_byte <= b;
		din.last_byte <= last;
		do @(posedge clk); while (!din.ready);
		g = steady ? 0 : idle_gap();
		if (g > 0) begin
			din.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_window(input logic [7:0] win[$]);
		for (int i = 0; i < win.size(); i++) begin
			send_item(win[i], i == win.size() - 1);
			sent++;
		end
		windows++;
	endtask

	task automatic settle();
		din.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_detection(input logic v);
		cfg.valid <= 1'b1;
		cfg.data_file_detection <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic make_window(input int kind, output logic [7:0] win[$]);
		int n;
		int p;
		int r;
		logic [63:0] pat;
		win = {};
		case (kind)
			KIND_ELF: begin
				win = {8'h7F, 8'h45, 8'h4C, 8'h46};
				win.push_back(8'($urandom_range(1, 2)));
				repeat (11) win.push_back(8'($urandom));
				win.push_back(8'($urandom_range(2, 3)));
				win.push_back(8'h00);
			end
			KIND_EICAR: begin
				for (p = 0; p < EICAR_LENGTH; p++)
					win.push_back(magic_scoreboard::eicar_char(p));
			end
			KIND_NOISE, KIND_LONG: begin
				n = (kind == KIND_LONG) ? $urandom_range(120, 200) : $urandom_range(1, 12);
				repeat (n) win.push_back(8'($urandom));
				if ($urandom_range(0, 2) == 0) begin
					case ($urandom_range(0, 4))
						0: win[0] = 8'h7F;
						1: win[0] = 8'h4D;
						2: win[0] = 8'h1F;
						3: win[0] = 8'h50;
						default: win[0] = 8'h58;
					endcase
				end
				if (kind == KIND_LONG && $urandom_range(0, 1) == 0) begin
					win[0] = 8'h4D;
					win[1] = 8'h5A;
				end
			end
			default: begin
				pat = magic_scoreboard::pattern(kind);
				for (p = 0; p < magic_scoreboard::pattern_len(kind); p++)
					win.push_back(pat[63-8*p -: 8]);
			end
		endcase
		if (kind == KIND_NOISE || kind == KIND_LONG)
			return;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			n = $urandom_range(1, win.size() - 1);
			while (win.size() > n) void'(win.pop_back());
			return;
		end
		if (r == 1) begin
			if (kind == KIND_ELF) begin
				p = $urandom_range(0, 6);
				if (p > 4)
					p = p + 11;
				win[p] = 8'($urandom);
			end else begin
				p = $urandom_range(0, win.size() - 1);
				win[p] = win[p] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		n = (kind == KIND_EICAR) ? $urandom_range(0, 3) : $urandom_range(0, 6);
		repeat (n) win.push_back(8'($urandom));
	endtask

	task automatic random_traffic(input int target);
		int start;
		int r;
		int kind;
		logic [7:0] win[$];
		start = sent;
		while (sent - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				kind = KIND_ELF;
			else if (r < 12)
				kind = KIND_EICAR;
			else if (r < 15)
				kind = KIND_LONG;
			else if (r < 30)
				kind = KIND_NOISE;
			else
				kind = $urandom_range(0, NUM_SIGS - 1);
			make_window(kind, win);
			send_window(win);
		end
	endtask

	initial begin
		logic [7:0] win[$];
		sb = new();
		steady = 1'b0;
		holding = 1'b0;
		hold_len = 0;
		sent = 0;
		windows = 0;
		cycles = 0;
		arst_n <= 1'b0;
		din.valid <= 1'b0;
		din.data_byte <= '0;
		din.last_byte <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.data_file_detection <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Data signatures are ignored until detection is enabled.
		send_window({8'h1F, 8'hA0});
		send_window({8'h4D, 8'h5A});
		settle();
		write_detection(1'b1);
		send_window({8'hFF});
		send_window({8'h00});
		send_window({8'h1F, 8'hA0});
		send_window({8'h1F, 8'h9D});
		send_window({8'h25, 8'h50, 8'h44, 8'h46});
		send_window({8'h50, 8'h4B, 8'h05, 8'h06});
		send_window({8'h50, 8'h4B, 8'h07, 8'h08});
		send_window({8'hD0, 8'hCF, 8'h11, 8'hE0});
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			write_detection((ph % 2 == 0) ? 1'b1 : 1'b0);
			steady = (ph == 2);
			random_traffic(440);
			settle();
			if (ph == 1) begin
				// Short windows pile up behind a stalled receiver.
				steady = 1'b1;
				hold_len = 300;
				wait (holding);
				@(posedge clk);
				repeat (40) begin
					make_window(KIND_NOISE, win);
					while (win.size() > 2) void'(win.pop_back());
					send_window(win);
				end
				steady = 1'b0;
				settle();
			end
		end

		$display("Sent %0d bytes in %0d windows and checked %0d results,", sb.bytes, windows,
			sb.results);
		$display("with detection on and off, random gaps, a long receiver stall and drains.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== file_magic_classifier.f =====
+incdir+hdl
hdl/fmc_pkg.sv
hdl/fmc_byte_if.sv
hdl/fmc_result_if.sv
hdl/fmc_cfg_if.sv
hdl/file_magic_classifier.sv
hdl/fmc_checker.sv
verif/testbench.sv
